### sv/mfgr_pkg.sv
`default_nettype none

package mfgr_pkg;

    // Screen geometry and store layout
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGES         = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES   = SCREEN_WIDTH * PAGES;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int PAGE_W        = (PAGES > 1) ? $clog2(PAGES) : 1;

    // Gauge geometry: outline plus one blank pixel on each side
    localparam int FILL_MARGIN = 4;
    localparam int FILL_OFFSET = 2;

    // Quotient bits of the fill division (fill never exceeds 251)
    localparam int QUOT_W = 8;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PIXEL = 2'd1,
        OP_GAUGE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic        [7:0]  pos_x;
        logic        [7:0]  pos_y;
        logic               pixel_on;
        logic        [7:0]  box_width;
        logic        [7:0]  box_height;
        logic signed [15:0] level;
        logic signed [15:0] range_low;
        logic signed [15:0] range_high;
        logic        [9:0]  byte_index;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        logic       span_error;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic clr_wr;
        logic pix_rd;
        logic pix_wr;
        logic rd_req;
        logic g_clamp;
        logic g_mul;
        logic g_div_step;
        logic g_fill;
        logic scan_rd;
        logic scan_wr;
        logic scan_adv;
        logic finish;
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic scan_hit;
        logic scan_last;
    } t_ctl_sts;

endpackage

`default_nettype wire

### sv/mfgr_ctrl.sv
`default_nettype none

module mfgr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire mfgr_pkg::t_op     i_op,
    input  wire mfgr_pkg::t_ctl_sts i_sts,
    output mfgr_pkg::t_ctl_cmd     o_ctl,
    output logic                   o_busy
);

    typedef enum logic [12:0] {
        S_INIT    = 13'h0001,
        S_IDLE    = 13'h0002,
        S_CLR     = 13'h0004,
        S_PIX_RD  = 13'h0008,
        S_PIX_WR  = 13'h0010,
        S_RD_REQ  = 13'h0020,
        S_RD_DONE = 13'h0040,
        S_G_CLAMP = 13'h0080,
        S_G_MUL   = 13'h0100,
        S_G_DIV   = 13'h0200,
        S_G_FILL  = 13'h0400,
        S_G_SCAN  = 13'h0800,
        S_G_WR    = 13'h1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_INIT: begin
                // clearing pass after reset, no result
                o_ctl.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    unique case (i_op)
                        mfgr_pkg::OP_CLEAR: n_state = S_CLR;
                        mfgr_pkg::OP_PIXEL: n_state = S_PIX_RD;
                        mfgr_pkg::OP_GAUGE: n_state = S_G_CLAMP;
                        mfgr_pkg::OP_READ:  n_state = S_RD_REQ;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                o_ctl.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_PIX_RD: begin
                o_ctl.pix_rd = 1'b1;
                n_state      = S_PIX_WR;
            end
            S_PIX_WR: begin
                o_ctl.pix_wr = 1'b1;
                o_ctl.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_RD_REQ: begin
                o_ctl.rd_req = 1'b1;
                n_state      = S_RD_DONE;
            end
            S_RD_DONE: begin
                o_ctl.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_G_CLAMP: begin
                o_ctl.g_clamp = 1'b1;
                n_state       = S_G_MUL;
            end
            S_G_MUL: begin
                o_ctl.g_mul = 1'b1;
                n_state     = S_G_DIV;
            end
            S_G_DIV: begin
                o_ctl.g_div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_G_FILL;
                end
            end
            S_G_FILL: begin
                o_ctl.g_fill = 1'b1;
                n_state      = S_G_SCAN;
            end
            S_G_SCAN: begin
                // touched byte: fetch it; otherwise step on
                if (i_sts.scan_hit) begin
                    o_ctl.scan_rd = 1'b1;
                    n_state       = S_G_WR;
                end else begin
                    o_ctl.scan_adv = 1'b1;
                    if (i_sts.scan_last) begin
                        o_ctl.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_G_WR: begin
                o_ctl.scan_wr  = 1'b1;
                o_ctl.scan_adv = 1'b1;
                if (i_sts.scan_last) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_G_SCAN;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

### sv/mfgr_dp.sv
`default_nettype none

module mfgr_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mfgr_pkg::t_cmd     i_cmd,
    input  wire mfgr_pkg::t_ctl_cmd i_ctl,
    output mfgr_pkg::t_ctl_sts      o_sts,
    output logic                    o_result_strobe,
    output mfgr_pkg::t_result       o_result
);

    localparam int AW = mfgr_pkg::ADDR_W;
    localparam int PW = mfgr_pkg::PAGE_W;
    localparam int QW = mfgr_pkg::QUOT_W;

    // Frame store
    logic [7:0]        r_mem [mfgr_pkg::STORE_BYTES];
    logic [7:0]        r_rd_data;

    mfgr_pkg::t_cmd    r_cmd;
    logic [AW-1:0]     r_clr_cnt;

    // Fill computation
    logic [15:0]       r_diff;
    logic [15:0]       r_den;
    logic [23:0]       r_rem;
    logic [22:0]       r_dsh;
    logic [QW-1:0]     r_quot;
    logic [2:0]        r_dcnt;
    logic [7:0]        r_fill;

    // Gauge scan position
    logic [7:0]        r_col;
    logic [7:0]        r_last_col;
    logic [PW-1:0]     r_page;

    logic              r_out_valid;
    mfgr_pkg::t_result r_out;

    logic signed [15:0] lvl_lo;
    logic signed [15:0] lvl_cl;
    logic signed [16:0] diff_full;
    logic signed [16:0] den_full;
    logic               span_err;
    logic               span_inv;
    logic               narrow;
    logic [7:0]         w_m4;
    logic [23:0]        prod;
    logic               div_ge;

    logic [7:0]         col_off;
    logic [7:0]         col;
    logic               col_on;
    logic               edge_col;
    logic               span_col;
    logic               fill_col;
    logic [7:0]         h_m1;
    logic [7:0]         scan_mask;
    logic [AW-1:0]      scan_addr;
    logic               page_last;

    logic               pix_on;
    logic [AW-1:0]      pix_addr;
    logic [7:0]         pix_mask;
    logic               rd_inrange;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [7:0]         mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    // Command capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
        end
    end

    // Clamp, span and flags
    always_comb begin
        lvl_lo    = (r_cmd.level < r_cmd.range_low) ? r_cmd.range_low : r_cmd.level;
        lvl_cl    = (lvl_lo > r_cmd.range_high) ? r_cmd.range_high : lvl_lo;
        diff_full = {lvl_cl[15], lvl_cl} - {r_cmd.range_low[15], r_cmd.range_low};
        den_full  = {r_cmd.range_high[15], r_cmd.range_high}
                  - {r_cmd.range_low[15], r_cmd.range_low};
        span_err  = (r_cmd.range_high == r_cmd.range_low);
        span_inv  = (r_cmd.range_high < r_cmd.range_low);
        narrow    = (r_cmd.box_width < 8'(mfgr_pkg::FILL_MARGIN));
        w_m4      = r_cmd.box_width - 8'(mfgr_pkg::FILL_MARGIN);
        prod      = r_diff * w_m4;
        div_ge    = (r_rem >= {1'b0, r_dsh});
    end

    // Multiply then restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.g_clamp) begin
            r_diff <= diff_full[15:0];
            r_den  <= den_full[15:0];
        end
        if (i_ctl.g_mul) begin
            r_rem  <= prod;
            r_dsh  <= {r_den, 7'b0};
            r_quot <= '0;
            r_dcnt <= 3'd7;
        end else if (i_ctl.g_div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - {1'b0, r_dsh};
            end
            r_quot <= {r_quot[QW-2:0], div_ge};
            r_dsh  <= {1'b0, r_dsh[22:1]};
            r_dcnt <= r_dcnt - 3'd1;
        end
        if (i_ctl.g_fill) begin
            if (span_err || narrow) begin
                r_fill <= '0;
            end else if (span_inv) begin
                r_fill <= w_m4;
            end else begin
                r_fill <= r_quot;
            end
        end
    end

    // Scan position: pages of a column, then the next column
    always_ff @(posedge i_clk) begin
        if (i_ctl.g_fill) begin
            r_col      <= '0;
            r_page     <= '0;
            r_last_col <= (r_cmd.box_width == 8'd0) ? 8'd1 : (r_cmd.box_width - 8'd1);
        end else if (i_ctl.scan_adv) begin
            if (page_last) begin
                r_page <= '0;
                r_col  <= r_col + 8'd1;
            end else begin
                r_page <= r_page + PW'(1);
            end
        end
    end

    // Bits of the current byte that the gauge sets
    always_comb begin
        logic [8:0] row_idx;
        logic [7:0] d;
        // zero width still draws the right edge one column left of x
        col_off  = ((r_cmd.box_width == 8'd0) && (r_col == 8'd1)) ? 8'hFF : r_col;
        col      = r_cmd.pos_x + col_off;
        col_on   = ({1'b0, col} < 9'(mfgr_pkg::SCREEN_WIDTH));
        h_m1     = r_cmd.box_height - 8'd1;
        edge_col = (col_off == 8'd0) || (col_off == (r_cmd.box_width - 8'd1));
        span_col = (col_off < r_cmd.box_width);
        fill_col = (col_off >= 8'(mfgr_pkg::FILL_OFFSET))
                && ({1'b0, col_off} < ({1'b0, r_fill} + 9'(mfgr_pkg::FILL_OFFSET)));
        scan_mask = '0;
        for (int b = 0; b < 8; b++) begin
            row_idx = 9'({r_page, 3'(b)});
            d       = row_idx[7:0] - r_cmd.pos_y;
            scan_mask[b] = (row_idx < 9'(mfgr_pkg::SCREEN_HEIGHT))
                && ((span_col && ((d == 8'd0) || (d == h_m1)))
                    || (edge_col && (d < r_cmd.box_height))
                    || (fill_col && (d >= 8'(mfgr_pkg::FILL_OFFSET))
                        && (({1'b0, d} + 9'(mfgr_pkg::FILL_OFFSET))
                            < {1'b0, r_cmd.box_height})));
        end
        scan_addr = AW'(col) + AW'(r_page) * AW'(mfgr_pkg::SCREEN_WIDTH);
        page_last = (r_page == PW'(mfgr_pkg::PAGES - 1));
    end

    // Single pixel and read addressing
    always_comb begin
        pix_on = ({1'b0, r_cmd.pos_x} < 9'(mfgr_pkg::SCREEN_WIDTH))
              && ({1'b0, r_cmd.pos_y} < 9'(mfgr_pkg::SCREEN_HEIGHT));
        pix_addr   = AW'(r_cmd.pos_x) + AW'(r_cmd.pos_y[7:3]) * AW'(mfgr_pkg::SCREEN_WIDTH);
        pix_mask   = 8'd1 << r_cmd.pos_y[2:0];
        rd_inrange = (32'(r_cmd.byte_index) < mfgr_pkg::STORE_BYTES);
    end

    // Store port selection
    always_comb begin
        mem_we    = i_ctl.clr_wr || (i_ctl.pix_wr && pix_on) || i_ctl.scan_wr;
        mem_waddr = r_clr_cnt;
        mem_wdata = '0;
        if (i_ctl.pix_wr) begin
            mem_waddr = pix_addr;
            mem_wdata = r_cmd.pixel_on ? (r_rd_data | pix_mask) : (r_rd_data & ~pix_mask);
        end else if (i_ctl.scan_wr) begin
            mem_waddr = scan_addr;
            mem_wdata = r_rd_data | scan_mask;
        end
        mem_re    = i_ctl.pix_rd || i_ctl.scan_rd || (i_ctl.rd_req && rd_inrange);
        mem_raddr = AW'(r_cmd.byte_index);
        if (i_ctl.pix_rd) begin
            mem_raddr = pix_addr;
        end else if (i_ctl.scan_rd) begin
            mem_raddr = scan_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // Clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_ctl.clr_wr) begin
            if (o_sts.clr_last) begin
                r_clr_cnt <= '0;
            end else begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_ctl.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_out.read_data  <= ((r_cmd.op == mfgr_pkg::OP_READ) && rd_inrange)
                              ? r_rd_data : 8'd0;
            r_out.span_error <= (r_cmd.op == mfgr_pkg::OP_GAUGE) && span_err;
        end
    end

    assign o_sts.clr_last  = (r_clr_cnt == AW'(mfgr_pkg::STORE_BYTES - 1));
    assign o_sts.div_last  = (r_dcnt == 3'd0);
    assign o_sts.scan_hit  = col_on && (scan_mask != 8'd0);
    assign o_sts.scan_last = (r_col == r_last_col) && page_last;

    assign o_result_strobe = r_out_valid;
    assign o_result        = r_out;

endmodule

`default_nettype wire

### sv/mono_framebuffer_gauge_rasterizer.sv
`default_nettype none

// Page-organised monochrome framebuffer with pixel and bar gauge drawing.
// Commands arrive on i_cmd and are taken when start is high and busy is
// low. Every command gives one result on o_result, shown for a single
// cycle with o_result_strobe; the receiver cannot hold it off.
// Op codes: clear the whole store, set or reset one pixel, draw a gauge
// (outline plus filled bar), read one store byte.
// Steps of each command up to the strobe:
//   clear  : one store byte written per cycle, then the result register
//   pixel  : read, modify-write, result register
//   read   : registered store read, result register
//   gauge  : set-up (clamp, multiply, 8-step divider, fill), then a visit
//            to each page of each covered column, with a read and a write
//            back for each on-screen byte the gauge touches; result register
// The store's one read port and one write port set the drawing rate.
// After reset the block clears the store, one byte a cycle, holding busy
// high; no result is given for that pass.

module mono_framebuffer_gauge_rasterizer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire mfgr_pkg::t_cmd    i_cmd,
    output logic                   busy,
    output logic                   o_result_strobe,
    output mfgr_pkg::t_result      o_result
);

    mfgr_pkg::t_ctl_cmd ctl;
    mfgr_pkg::t_ctl_sts sts;

    mfgr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_cmd.op),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    mfgr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (i_cmd),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

`ifndef NO_ASSERTIONS
    // a transfer always puts the block to work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy");

    // results come only as the block returns to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (!busy && $past(busy)))
        else $error("result strobe outside end of command");

    // a strobe is never held high
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe held");
`endif

endmodule

`default_nettype wire

### bench/mfgr_checker.sv
`timescale 1ns / 100ps

// Watches the command and result channels of the framebuffer block, keeps a
// mirror of its frame store, predicts one result per accepted command and
// compares every strobed result against the oldest prediction.
module mfgr_checker
    import mfgr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire logic    busy,
    input  wire t_cmd    i_cmd,
    input  wire logic    o_result_strobe,
    input  wire t_result o_result,
    output int           fail_count,
    output int           pending_count,
    output int           checked_count,
    output int           span_flags,
    output int           lit_reads
);

    // Mirror of the frame store and results still owed by the block
    logic [7:0] frame_mirror [STORE_BYTES];
    t_result    due_results[$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
        span_flags    = 0;
        lit_reads     = 0;
        foreach (frame_mirror[k]) frame_mirror[k] = 8'h00;
    end

    // One pixel: coordinates wrap at 8 bits, off-screen pixels are dropped
    function automatic void plot_dot(int x, int y, bit on);
        int         cx;
        int         cy;
        int         idx;
        logic [7:0] bitmask;
        cx = x & 255;
        cy = y & 255;
        if (cx >= SCREEN_WIDTH || cy >= SCREEN_HEIGHT) return;
        idx     = cx + (cy / 8) * SCREEN_WIDTH;
        bitmask = 8'b1 << (cy % 8);
        if (on) frame_mirror[idx] = frame_mirror[idx] | bitmask;
        else    frame_mirror[idx] = frame_mirror[idx] & ~bitmask;
    endfunction

    // Outline plus bar; returns the zero-span flag
    function automatic bit draw_gauge_bar(t_cmd c);
        int x;
        int y;
        int w;
        int h;
        int val;
        int lo;
        int hi;
        int fill;
        bit span_zero;
        x    = c.pos_x;
        y    = c.pos_y;
        w    = c.box_width;
        h    = c.box_height;
        val  = int'($signed(c.level));
        lo   = int'($signed(c.range_low));
        hi   = int'($signed(c.range_high));
        fill = 0;
        span_zero = (hi == lo);
        // clamp low first, then high: an inverted range ends at range_high
        if (val < lo) val = lo;
        if (val > hi) val = hi;
        if (!span_zero && w >= FILL_MARGIN)
            fill = ((val - lo) * (w - FILL_MARGIN)) / (hi - lo);
        for (int i = 0; i < w; i++) begin
            plot_dot(x + i, y, 1'b1);
            plot_dot(x + i, y + h - 1, 1'b1);
        end
        for (int j = 0; j < h; j++) begin
            plot_dot(x, y + j, 1'b1);
            plot_dot(x + w - 1, y + j, 1'b1);
        end
        for (int j = FILL_OFFSET; j + FILL_OFFSET < h; j++)
            for (int i = 0; i < fill; i++)
                plot_dot(x + FILL_OFFSET + i, y + j, 1'b1);
        return span_zero;
    endfunction

    function automatic t_result apply_command(t_cmd c);
        t_result r;
        r = '0;
        case (c.op)
            OP_CLEAR: begin
                foreach (frame_mirror[k]) frame_mirror[k] = 8'h00;
            end
            OP_PIXEL: begin
                plot_dot(c.pos_x, c.pos_y, c.pixel_on);
            end
            OP_GAUGE: begin
                r.span_error = draw_gauge_bar(c);
            end
            default: begin
                if (int'(c.byte_index) < STORE_BYTES) r.read_data = frame_mirror[c.byte_index];
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            // the block blanks its store after reset
            foreach (frame_mirror[k]) frame_mirror[k] = 8'h00;
            due_results.delete();
        end else begin
            // result transfer: compare against the oldest prediction
            if (o_result_strobe === 1'b1) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, got data %02h span_error %b",
                             $time, o_result.read_data, o_result.span_error);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    checked_count++;
                    if (o_result.read_data !== want.read_data) begin
                        $display("%0t: read_data mismatch, expected %02h, got %02h",
                                 $time, want.read_data, o_result.read_data);
                        fail_count++;
                    end
                    if (o_result.span_error !== want.span_error) begin
                        $display("%0t: span_error mismatch, expected %b, got %b",
                                 $time, want.span_error, o_result.span_error);
                        fail_count++;
                    end
                    if (want.span_error) span_flags++;
                    if (want.read_data != 8'h00) lit_reads++;
                end
            end
            // command transfer: predict its result
            if (start === 1'b1 && busy === 1'b0) due_results.push_back(apply_command(i_cmd));
        end
        pending_count = due_results.size();
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mfgr_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 600;
    localparam int SETTLE_CYCLES = 64;
    // worst case is a full-screen gauge for every command
    localparam int CYCLE_LIMIT   = 12_000_000;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_result_strobe;
    t_result o_result;

    int fail_count;
    int pending_count;
    int checked_count;
    int span_flags;
    int lit_reads;
    int cycle_count = 0;
    int sent_by_op [4];
    int last_x = 0;
    int last_y = 0;
    bit burst  = 1'b0;

    mono_framebuffer_gauge_rasterizer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_cmd           (i_cmd),
        .busy            (busy),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

    mfgr_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .checked_count   (checked_count),
        .span_flags      (span_flags),
        .lit_reads       (lit_reads)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("mono_framebuffer_gauge_rasterizer regression: fail");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(t_op op, int x, int y, bit on, int w, int h,
                                      int lvl, int lo, int hi, int idx);
        t_cmd c;
        c            = '0;
        c.op         = op;
        c.pos_x      = 8'(x);
        c.pos_y      = 8'(y);
        c.pixel_on   = on;
        c.box_width  = 8'(w);
        c.box_height = 8'(h);
        c.level      = 16'(lvl);
        c.range_low  = 16'(lo);
        c.range_high = 16'(hi);
        c.byte_index = 10'(idx);
        return c;
    endfunction

    // Random command: every field random, then the fields that matter shaped
    function automatic t_cmd random_command();
        t_cmd        c;
        logic [95:0] raw;
        int          pick;
        int          kind;
        int          lo;
        int          hi;
        raw  = {$urandom(), $urandom(), $urandom()};
        c    = raw[$bits(t_cmd)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            c.op = OP_CLEAR;
        end else if (pick < 40) begin
            c.op = OP_PIXEL;
            if ($urandom_range(0, 9) < 8) begin
                c.pos_x = 8'($urandom_range(0, SCREEN_WIDTH - 1));
                c.pos_y = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
            end
            c.pixel_on = ($urandom_range(0, 3) != 0);
            last_x = c.pos_x;
            last_y = c.pos_y;
        end else if (pick < 65) begin
            c.op = OP_GAUGE;
            // mostly small boxes, now and then a full-range one
            if ($urandom_range(0, 19) != 0) begin
                c.box_width  = 8'($urandom_range(0, 40));
                c.box_height = 8'($urandom_range(0, 24));
            end
            if ($urandom_range(0, 9) < 8) begin
                c.pos_x = 8'($urandom_range(0, SCREEN_WIDTH - 1));
                c.pos_y = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
            end
            kind = $urandom_range(0, 9);
            if (kind == 1) begin
                c.range_high = c.range_low;
            end else if (kind == 2) begin
                lo = $urandom_range(0, 200) - 100;
                hi = lo - $urandom_range(1, 100);
                c.range_low  = 16'(lo);
                c.range_high = 16'(hi);
            end else if (kind > 2) begin
                lo = $urandom_range(0, 400) - 200;
                hi = lo + $urandom_range(1, 300);
                c.range_low  = 16'(lo);
                c.range_high = 16'(hi);
                c.level      = 16'(lo - 30 + $urandom_range(0, hi - lo + 60));
            end
            last_x = c.pos_x;
            last_y = c.pos_y;
        end else begin
            c.op = OP_READ;
            // half the reads look near the latest drawing
            if ($urandom_range(0, 1) != 0)
                c.byte_index = 10'(((last_y / 8 + $urandom_range(0, 2)) % PAGES) * SCREEN_WIDTH
                                   + (last_x + $urandom_range(0, 31)) % SCREEN_WIDTH);
        end
        return c;
    endfunction

    // Command transfer, called and returning at a falling edge
    task automatic issue(input t_cmd c, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        @(negedge i_clk);
        sent_by_op[int'(c.op)]++;
    endtask

    initial begin
        foreach (sent_by_op[k]) sent_by_op[k] = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: pixel corners and off-screen drops, reads, gauge corner cases
        issue(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_PIXEL, 0, 0, 1, 0, 0, 0, 0, 0, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_PIXEL, 127, 63, 1, 0, 0, 0, 0, 0, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_PIXEL, 128, 5, 1, 0, 0, 0, 0, 0, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_PIXEL, 3, 64, 1, 0, 0, 0, 0, 0, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_PIXEL, 255, 255, 1, 0, 0, 0, 0, 0, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 7 * 128 + 127), $urandom_range(0, 5));
        issue(make_cmd(OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_GAUGE, 10, 8, 0, 20, 12, 50, 0, 100, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 128 + 12), $urandom_range(0, 5));
        // zero span, narrow, short and inverted gauges
        issue(make_cmd(OP_GAUGE, 40, 0, 0, 10, 10, 5, 7, 7, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_GAUGE, 60, 0, 0, 3, 10, 5, 0, 10, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_GAUGE, 70, 0, 0, 20, 4, 5, 0, 10, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_GAUGE, 90, 20, 0, 20, 10, 0, 100, -100, 0), $urandom_range(0, 5));
        // wrap round the coordinate space, then value extremes
        issue(make_cmd(OP_GAUGE, 250, 250, 0, 20, 20, 1, 0, 2, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_GAUGE, 0, 40, 0, 30, 10, 32767, -32768, 32767, 0),
              $urandom_range(0, 5));
        issue(make_cmd(OP_GAUGE, 30, 40, 0, 30, 10, -32768, -32768, 32767, 0),
              $urandom_range(0, 5));
        issue(make_cmd(OP_GAUGE, 5, 5, 0, 0, 0, 0, 0, 1, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_GAUGE, 0, 0, 0, 255, 255, 1000, -1000, 1000, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1023), $urandom_range(0, 5));
        issue(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 2 * 128 + 92), $urandom_range(0, 5));
        issue(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), $urandom_range(0, 5));
        issue(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 2 * 128 + 92), $urandom_range(0, 5));

        // Random part, alternating bursts with no gaps and gappy stretches
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0) burst = !burst;
            issue(random_command(), burst ? 0 : $urandom_range(0, 5));
        end
        start <= 1'b0;

        // Drain, then allow for a stray late result
        while (pending_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("%0d commands sent: %0d clear, %0d pixel, %0d gauge, %0d read",
                 sent_by_op[0] + sent_by_op[1] + sent_by_op[2] + sent_by_op[3],
                 sent_by_op[int'(OP_CLEAR)], sent_by_op[int'(OP_PIXEL)],
                 sent_by_op[int'(OP_GAUGE)], sent_by_op[int'(OP_READ)]);
        $display("%0d results checked, %0d with zero-span flag, %0d reads of non-blank bytes",
                 checked_count, span_flags, lit_reads);
        if (fail_count == 0) begin
            $display("mono_framebuffer_gauge_rasterizer regression: pass");
        end else begin
            $display("mono_framebuffer_gauge_rasterizer regression: fail");
        end
        $finish;
    end

endmodule
